[rtl/core/acet_pkg.sv]
// acet_pkg: types and constants for the contact event tracker.
// Item and result structs, event codes, internal evaluation struct.
// No dependencies.
package acet_pkg;

	localparam int ID_W    = 6;
	localparam int LAYER_W = 3;
	localparam int POS_W   = 16;
	localparam int SIZE_W  = 16;
	localparam int MASK_W  = 64;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_BEGIN = 2'd1,
		EV_STAY  = 2'd2,
		EV_END   = 2'd3
	} acet_event_t;

	typedef struct packed {
		logic [ID_W-1:0]           left_id;
		logic [ID_W-1:0]           right_id;
		logic [LAYER_W-1:0]        left_layer;
		logic [LAYER_W-1:0]        right_layer;
		logic signed [POS_W-1:0]   left_x;
		logic signed [POS_W-1:0]   left_y;
		logic signed [POS_W-1:0]   right_x;
		logic signed [POS_W-1:0]   right_y;
		logic [SIZE_W-1:0]         left_width;
		logic [SIZE_W-1:0]         left_height;
		logic [SIZE_W-1:0]         right_width;
		logic [SIZE_W-1:0]         right_height;
	} acet_pair_t;

	typedef struct packed {
		logic [1:0] contact_event;
		logic       touching_now;
	} acet_result_t;

	typedef struct packed {
		logic enabled;
		logic overlap;
	} acet_eval_t;

endpackage

[rtl/core/aabb_contact_event_tracker.sv]
// aabb_contact_event_tracker: top level, contact bit store and event logic.
// Depends on acet_pkg, acet_ram, acet_pair_eval.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------
//  pair in   | start, busy        | pair (acet_pair_t)
//  result    | done (strobe)      | result (acet_result_t)
//  config    | mask_we            | mask_wdata (64 bits)
//
// One item per cycle while busy is low; results leave via valid_s1, done_q.
// The contact bit store is a RAM read at acceptance and written in the
// next cycle; a back-to-back item on the same pair takes the bit from a
// bypass. After reset busy is high while a clearing pass zeroes the store.
// The receiver cannot stall; results are never held back.
module aabb_contact_event_tracker #(
	parameter int NUM_LAYERS = 8,
	parameter int ID_BITS    = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  acet_pkg::acet_pair_t          pair,
	output logic                          done,
	output acet_pkg::acet_result_t        result,
	input  logic                          mask_we,
	input  logic [acet_pkg::MASK_W-1:0]   mask_wdata
);

	localparam int KEY_BITS = 2 * ID_BITS;
	localparam int DEPTH    = 1 << KEY_BITS;

	logic [acet_pkg::MASK_W-1:0] mask_q;
	logic                        clr_active_q;
	logic [KEY_BITS-1:0]         clr_addr_q;

	logic                        accept;
	logic [KEY_BITS-1:0]         key_in;

	logic                        valid_s1;
	acet_pkg::acet_pair_t        pair_s1;
	logic [KEY_BITS-1:0]         key_s1;
	logic                        fwd_hit_s1;
	logic                        fwd_val_s1;

	acet_pkg::acet_eval_t        ev;
	logic                        prev;
	logic                        now;
	logic                        wr_s1;
	acet_pkg::acet_event_t       event_code;

	logic                        ram_we;
	logic [KEY_BITS-1:0]         ram_waddr;
	logic                        ram_wdata;
	logic                        ram_rdata;

	logic                        done_q;
	acet_pkg::acet_result_t      result_q;

	assign busy   = clr_active_q;
	assign accept = start && !clr_active_q;
	assign key_in = {ID_BITS'(pair.left_id), ID_BITS'(pair.right_id)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (mask_we) begin
			mask_q <= mask_wdata;
		end
	end

	// clear the contact store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pair_s1    <= pair;
			key_s1     <= key_in;
			fwd_hit_s1 <= wr_s1 && (key_s1 == key_in);
			fwd_val_s1 <= ev.overlap;
		end
	end

	acet_pair_eval #(
		.NUM_LAYERS(NUM_LAYERS)
	) u_eval (
		.pair(pair_s1),
		.mask(mask_q),
		.ev  (ev)
	);

	always_comb begin
		prev  = fwd_hit_s1 ? fwd_val_s1 : ram_rdata;
		now   = ev.enabled && ev.overlap;
		wr_s1 = valid_s1 && ev.enabled;
		if (!ev.enabled) begin
			event_code = acet_pkg::EV_NONE;
		end else begin
			case ({ev.overlap, prev})
				2'b10:   event_code = acet_pkg::EV_BEGIN;
				2'b11:   event_code = acet_pkg::EV_STAY;
				2'b01:   event_code = acet_pkg::EV_END;
				default: event_code = acet_pkg::EV_NONE;
			endcase
		end
	end

	always_comb begin
		if (clr_active_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = 1'b0;
		end else begin
			ram_we    = wr_s1;
			ram_waddr = key_s1;
			ram_wdata = ev.overlap;
		end
	end

	acet_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_contact_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(key_in),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.contact_event <= event_code;
			result_q.touching_now  <= now;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done_q)
		else $error("result strobe missing for item");

	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !valid_s1)
		else $error("item in flight during clearing pass");

	a_touching_event: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result.touching_now) |->
			(result.contact_event == acet_pkg::EV_BEGIN
			|| result.contact_event == acet_pkg::EV_STAY))
		else $error("touching result without begin or stay");

	a_bypass_same_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && $past(wr_s1) && $past(ev.overlap) && (key_s1 == $past(key_s1)))
			|-> prev)
		else $error("contact bit lost on back-to-back pair");

endmodule

[rtl/core/acet_ram.sv]
// acet_ram: generic single-write, single-read RAM with registered read.
// Read during write to the same address returns the old data.
// No dependencies.
module acet_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/acet_pair_eval.sv]
// acet_pair_eval: layer mask lookup and exact box overlap test for one pair.
// Depends on acet_pkg.
module acet_pair_eval #(
	parameter int NUM_LAYERS = 8
) (
	input  acet_pkg::acet_pair_t          pair,
	input  logic [acet_pkg::MASK_W-1:0]   mask,
	output acet_pkg::acet_eval_t          ev
);

	logic [acet_pkg::LAYER_W-1:0] row;
	logic [acet_pkg::LAYER_W-1:0] col;
	logic                         layers_ok;
	logic signed [acet_pkg::POS_W:0] dx;
	logic signed [acet_pkg::POS_W:0] dy;
	logic [acet_pkg::POS_W-1:0]   adx;
	logic [acet_pkg::POS_W-1:0]   ady;
	logic [acet_pkg::SIZE_W:0]    sw;
	logic [acet_pkg::SIZE_W:0]    sh;

	always_comb begin
		layers_ok = ({1'b0, pair.left_layer} < (acet_pkg::LAYER_W+1)'(NUM_LAYERS))
			&& ({1'b0, pair.right_layer} < (acet_pkg::LAYER_W+1)'(NUM_LAYERS));
		if (pair.right_layer < pair.left_layer) begin
			row = pair.right_layer;
			col = pair.left_layer;
		end else begin
			row = pair.left_layer;
			col = pair.right_layer;
		end
		ev.enabled = layers_ok && mask[{row, col}];

		dx  = {pair.left_x[acet_pkg::POS_W-1], pair.left_x}
			- {pair.right_x[acet_pkg::POS_W-1], pair.right_x};
		dy  = {pair.left_y[acet_pkg::POS_W-1], pair.left_y}
			- {pair.right_y[acet_pkg::POS_W-1], pair.right_y};
		adx = dx[acet_pkg::POS_W] ? acet_pkg::POS_W'(-dx) : dx[acet_pkg::POS_W-1:0];
		ady = dy[acet_pkg::POS_W] ? acet_pkg::POS_W'(-dy) : dy[acet_pkg::POS_W-1:0];
		sw  = {1'b0, pair.left_width} + {1'b0, pair.right_width};
		sh  = {1'b0, pair.left_height} + {1'b0, pair.right_height};
		ev.overlap = ({adx, 1'b0} <= sw) && ({ady, 1'b0} <= sh);
	end

endmodule

[dv/tb.sv]
// tb: self-checking bench for aabb_contact_event_tracker.
// Holds the contact scoreboard class, the pair and mask drivers and the result monitor.
// Depends on acet_pkg and the tracker RTL.
module tb;
	import acet_pkg::*;

	localparam int MASK_STRIDE = 8;
	localparam int KEY_W       = 2 * ID_W;
	localparam int MAX_GAP     = 5;

	class contact_ledger;
		logic [MASK_W-1:0] layer_mask;
		bit                touch_bits [2**KEY_W];
		acet_result_t      pending_q [$];
		int                errors;

		function new();
			layer_mask = '0;
			errors = 0;
			foreach (touch_bits[i])
				touch_bits[i] = 1'b0;
		endfunction

		function void note_pair(acet_pair_t p);
			int unsigned  row;
			int unsigned  col;
			int           dx;
			int           dy;
			int           sw;
			int           sh;
			logic [KEY_W-1:0] key;
			bit           hit;
			acet_result_t r;
			row = p.left_layer;
			col = p.right_layer;
			if (col < row) begin
				row = p.right_layer;
				col = p.left_layer;
			end
			r = '0;
			r.contact_event = EV_NONE;
			if (layer_mask[row * MASK_STRIDE + col]) begin
				dx = $signed(p.left_x) - $signed(p.right_x);
				dy = $signed(p.left_y) - $signed(p.right_y);
				if (dx < 0)
					dx = -dx;
				if (dy < 0)
					dy = -dy;
				sw = p.left_width + p.right_width;
				sh = p.left_height + p.right_height;
				hit = (2 * dx <= sw) && (2 * dy <= sh);
				key = {p.left_id, p.right_id};
				if (hit)
					r.contact_event = touch_bits[key] ? EV_STAY : EV_BEGIN;
				else
					r.contact_event = touch_bits[key] ? EV_END : EV_NONE;
				r.touching_now = hit;
				touch_bits[key] = hit;
			end
			pending_q.push_back(r);
		endfunction

		function void check_result(acet_result_t got);
			acet_result_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, got event %0d touching %0d",
					$time, got.contact_event, got.touching_now);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.contact_event !== want.contact_event) begin
				$display("%0t: contact_event mismatch, expected %0d, got %0d",
					$time, want.contact_event, got.contact_event);
				errors++;
			end
			if (got.touching_now !== want.touching_now) begin
				$display("%0t: touching_now mismatch, expected %0d, got %0d",
					$time, want.touching_now, got.touching_now);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	acet_pair_t        pair;
	logic              done;
	acet_result_t      result;
	logic              mask_we;
	logic [MASK_W-1:0] mask_wdata;

	contact_ledger ledger;

	aabb_contact_event_tracker u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pair       (pair),
		.done       (done),
		.result     (result),
		.mask_we    (mask_we),
		.mask_wdata (mask_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_400_000;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			ledger.check_result(result);
	end

	function automatic int offset_coord(int base, int delta);
		if (base + delta > 32767 || base + delta < -32768)
			return base - delta;
		return base + delta;
	endfunction

	function automatic acet_pair_t mk_pair(int lid, int rid, int ll, int rl,
			int lx, int ly, int rx, int ry, int lw, int lh, int rw, int rh);
		acet_pair_t p;
		p.left_id      = ID_W'(lid);
		p.right_id     = ID_W'(rid);
		p.left_layer   = LAYER_W'(ll);
		p.right_layer  = LAYER_W'(rl);
		p.left_x       = POS_W'(lx);
		p.left_y       = POS_W'(ly);
		p.right_x      = POS_W'(rx);
		p.right_y      = POS_W'(ry);
		p.left_width   = SIZE_W'(lw);
		p.left_height  = SIZE_W'(lh);
		p.right_width  = SIZE_W'(rw);
		p.right_height = SIZE_W'(rh);
		return p;
	endfunction

	// mostly nearby boxes from a small id pool; some items sit on the overlap edge
	function automatic acet_pair_t gen_pair();
		acet_pair_t   p;
		logic [191:0] noise;
		int           roll;
		int           lx;
		int           ly;
		int           half;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		p = noise[$bits(acet_pair_t)-1:0];
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return p;
		if (roll >= 25) begin
			p.left_id  = ID_W'($urandom_range(0, 7));
			p.right_id = ID_W'($urandom_range(0, 7));
		end
		p.left_width   = SIZE_W'($urandom_range(0, 400));
		p.left_height  = SIZE_W'($urandom_range(0, 400));
		p.right_width  = SIZE_W'($urandom_range(0, 400));
		p.right_height = SIZE_W'($urandom_range(0, 400));
		lx = $signed(p.left_x);
		ly = $signed(p.left_y);
		if (roll < 45) begin
			half = (p.left_width + p.right_width) / 2 + $urandom_range(0, 1);
			p.right_x = POS_W'(offset_coord(lx, $urandom_range(0, 1) ? half : -half));
			half = (p.left_height + p.right_height) / 2 + $urandom_range(0, 1);
			p.right_y = POS_W'(offset_coord(ly, $urandom_range(0, 1) ? half : -half));
		end else begin
			p.right_x = POS_W'(offset_coord(lx, int'($urandom_range(0, 600)) - 300));
			p.right_y = POS_W'(offset_coord(ly, int'($urandom_range(0, 600)) - 300));
		end
		return p;
	endfunction

	// entered and left at a falling edge; start stays high when the next item has no gap
	task automatic send_pair(input acet_pair_t p, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		pair  <= p;
		do @(posedge clk); while (busy !== 1'b0);
		ledger.note_pair(p);
		@(negedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(negedge clk); while (ledger.pending_q.size() != 0);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] value);
		drain_results();
		repeat (3) @(negedge clk);
		mask_we    <= 1'b1;
		mask_wdata <= value;
		ledger.layer_mask = value;
		@(negedge clk);
		mask_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [MASK_W-1:0] value, input int count);
		bit steady;
		int gap;
		write_mask(value);
		steady = 1'b0;
		repeat (count) begin
			if ($urandom_range(0, 39) == 0)
				steady = ~steady;
			gap = steady ? 0 : $urandom_range(0, MAX_GAP);
			send_pair(gen_pair(), gap);
			if ($urandom_range(0, 99) == 0)
				drain_results();
		end
	endtask

	initial begin
		logic [MASK_W-1:0] dir_mask;
		ledger     = new();
		arst_n     = 1'b0;
		start      = 1'b0;
		pair       = '0;
		mask_we    = 1'b0;
		mask_wdata = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);

		// every layer pair on except layers 3 and 4
		dir_mask = ~(64'd1 << (3 * MASK_STRIDE + 4));
		write_mask(dir_mask);
		send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(1, 2, 7, 2, 0, 0, 5, 0, 4, 0, 6, 0), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(2, 1, 7, 2, 0, 0, 5, 0, 4, 0, 6, 0), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(1, 2, 7, 2, 0, 0, 5, 0, 4, 0, 5, 0), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(1, 2, 2, 7, 0, 0, 0, -7, 0, 7, 0, 7), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(1, 2, 2, 7, 0, 0, 0, -7, 0, 7, 0, 6), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(63, 63, 7, 7, -32768, 32767, 32767, -32768,
			65535, 65535, 65535, 65535), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(63, 63, 7, 7, -32768, 32767, 32767, -32768,
			65535, 65535, 65534, 65535), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(63, 0, 6, 1, 32767, -32768, -32768, -32768,
			65535, 0, 65535, 0), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(5, 6, 3, 3, 100, 100, 110, 90, 30, 30, 30, 30), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(5, 6, 3, 4, 100, 100, 110, 90, 30, 30, 30, 30), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(5, 6, 4, 3, 100, 100, 900, 90, 30, 30, 30, 30), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(5, 6, 3, 3, 100, 100, 110, 90, 30, 30, 30, 30), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(5, 6, 4, 3, 100, 100, 110, 90, 30, 30, 30, 30), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(5, 6, 3, 3, 100, 100, 900, 90, 30, 30, 30, 30), $urandom_range(0, MAX_GAP));
		send_pair(mk_pair(42, 21, 5, 2, -21846, 21845, -21840, 21840,
			43690, 21845, 21845, 43690), $urandom_range(0, MAX_GAP));

		run_phase({MASK_W{1'b1}}, 300);
		run_phase('0, 80);
		run_phase({$urandom, $urandom}, 300);
		run_phase({$urandom, $urandom} & {$urandom, $urandom}, 200);
		run_phase(64'h8040_2010_0804_0201, 150);
		run_phase({$urandom, $urandom}, 320);

		drain_results();
		repeat (4) @(negedge clk);
		if (ledger.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
